FILE: hw/rtl/fcca_pkg.sv
// Shared types and constants of the cluster chain allocator.
`default_nettype none

package fcca_pkg;

   localparam int CW    = 12;  // cluster number and link width
   localparam int NW    = 13;  // cluster counts, may reach 4096
   localparam int SW    = 2;   // status width
   localparam int MW    = 2;   // mode width
   localparam int REMCW = 4;   // step counter of the remainder unit

   localparam logic [CW-1:0] LINK_FREE = 12'h000;
   localparam logic [CW-1:0] LINK_END  = 12'hFFF;

   localparam logic [NW-1:0] CSR_RESET = 13'd4096;

   localparam logic [MW-1:0] MODE_NEW    = 2'd0;
   localparam logic [MW-1:0] MODE_EXTEND = 2'd1;
   localparam logic [MW-1:0] MODE_TRUNC  = 2'd2;
   localparam logic [MW-1:0] MODE_FREE   = 2'd3;

   localparam logic [SW-1:0] STAT_OK     = 2'd0;
   localparam logic [SW-1:0] STAT_FULL   = 2'd1;
   localparam logic [SW-1:0] STAT_BROKEN = 2'd2;

   typedef struct packed {
      logic [MW-1:0] mode;
      logic [CW-1:0] first_cluster;
      logic [CW-1:0] count;
   } req_type;

   typedef struct packed {
      logic [CW-1:0] cluster;
      logic [CW-1:0] amount;
      logic [SW-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic          en;
      logic [CW-1:0] addr;
      logic [CW-1:0] data;
   } ram_wr_type;

endpackage

`default_nettype wire

FILE: hw/rtl/fat_cluster_chain_allocator.sv
// Top level of the FAT12-style cluster chain allocator.
//
//   channel  ports                          direction  handshake
//   req      req_valid/req_ready/req_payload   in       valid-ready
//   rsp      rsp_valid/rsp_ready/rsp_payload   out      valid-ready
//   csr      csr_wr_en/csr_wr_data             in       write strobe
//
// Cycles: one transaction at a time. A new file scans table entries up to
// the managed count, after a remainder step when the search pointer lies
// beyond a reduced count. Extend, truncate and free walk the chain at one
// entry per cycle; extend then adds a search and a link write per linked
// cluster, truncate and free walk the chain a second time. The single
// read port of the link table sets this pace.
// Reset: a clearing pass writes every entry free, with req_ready low; csr
// writes are taken during it.
// Stalls: a finished result waits in the rsp register; the next request is
// taken while it waits.
`default_nettype none

module fat_cluster_chain_allocator
   import fcca_pkg::*;
#(
   parameter int MAX_CLUSTERS = 4096
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire req_type       req_payload,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output rsp_type            rsp_payload,
   input  wire logic          csr_wr_en,
   input  wire logic [NW-1:0] csr_wr_data
);

   logic [NW-1:0] csr_count_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   logic          seq_res_valid;
   rsp_type       seq_res;
   logic          res_taken;
   ram_wr_type    ram_wr;
   logic [CW-1:0] ram_rd_addr;
   logic [CW-1:0] ram_rd_data;
   logic          rem_start;
   logic          rem_done;
   logic [CW-1:0] rem_value;
   logic [NW-1:0] managed;
   logic [CW-1:0] search_ptr;

   // hold the managed-cluster count
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_count_ff <= CSR_RESET;
      end else if (csr_wr_en) begin
         csr_count_ff <= csr_wr_data;
      end
   end

   // move a finished result into the output register when it is free
   assign res_taken = seq_res_valid && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_taken) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_taken) begin
         rsp_ff <= seq_res;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   fcca_seq #(
      .MAX_CLUSTERS(MAX_CLUSTERS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .csr_count  (csr_count_ff),
      .req_valid  (req_valid),
      .req        (req_payload),
      .req_ready  (req_ready),
      .res_valid  (seq_res_valid),
      .res        (seq_res),
      .res_taken  (res_taken),
      .ram_wr     (ram_wr),
      .ram_rd_addr(ram_rd_addr),
      .ram_rd_data(ram_rd_data),
      .rem_start  (rem_start),
      .rem_done   (rem_done),
      .rem_value  (rem_value),
      .managed    (managed),
      .search_ptr (search_ptr)
   );

   fcca_link_ram #(
      .MAX_CLUSTERS(MAX_CLUSTERS)
   ) u_link_ram (
      .clock  (clock),
      .wr     (ram_wr),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // fold the search pointer into range after the managed count shrank
   fcca_rem_unit u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (search_ptr),
      .divisor  (managed),
      .done     (rem_done),
      .remainder(rem_value)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/fcca_link_ram.sv
// Link table memory: one write port, one registered read port.
`default_nettype none

module fcca_link_ram
   import fcca_pkg::*;
#(
   parameter int MAX_CLUSTERS = 4096
) (
   input  wire logic          clock,
   input  wire ram_wr_type    wr,
   input  wire logic [CW-1:0] rd_addr,
   output logic      [CW-1:0] rd_data
);

   localparam int AW = $clog2(MAX_CLUSTERS);

   logic [CW-1:0] mem_ff [MAX_CLUSTERS];
   logic [CW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr[AW-1:0]] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr[AW-1:0]];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/fcca_rem_unit.sv
// Bit-serial restoring remainder, one dividend bit per cycle.
`default_nettype none

module fcca_rem_unit
   import fcca_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [CW-1:0] dividend,
   input  wire logic [NW-1:0] divisor,
   output logic               done,
   output logic      [CW-1:0] remainder
);

   logic [NW-1:0]    rem_ff, rem_in;
   logic [CW-1:0]    sh_ff;
   logic [REMCW-1:0] cnt_ff;
   logic             done_ff;
   logic [NW-1:0]    trial;

   // shift in the next dividend bit, subtract when it fits
   always_comb begin
      trial = {rem_ff[CW-1:0], sh_ff[CW-1]};
      if (trial >= divisor) begin
         rem_in = trial - divisor;
      end else begin
         rem_in = trial;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff <= '0;
            sh_ff  <= dividend;
            cnt_ff <= REMCW'(CW);
         end else if (cnt_ff != '0) begin
            rem_ff  <= rem_in;
            sh_ff   <= {sh_ff[CW-2:0], 1'b0};
            cnt_ff  <= cnt_ff - REMCW'(1);
            done_ff <= (cnt_ff == REMCW'(1));
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff[CW-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/fcca_seq.sv
// Sequencer: clearing pass, chain walks, next-fit search and table updates.
`default_nettype none

module fcca_seq
   import fcca_pkg::*;
#(
   parameter int MAX_CLUSTERS = 4096
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [NW-1:0] csr_count,
   input  wire logic          req_valid,
   input  wire req_type       req,
   output logic               req_ready,
   output logic               res_valid,
   output rsp_type            res,
   input  wire logic          res_taken,
   output ram_wr_type         ram_wr,
   output logic      [CW-1:0] ram_rd_addr,
   input  wire logic [CW-1:0] ram_rd_data,
   output logic               rem_start,
   input  wire logic          rem_done,
   input  wire logic [CW-1:0] rem_value,
   output logic      [NW-1:0] managed,
   output logic      [CW-1:0] search_ptr
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_SRCH_START,
      ST_SRCH_MOD,
      ST_SRCH,
      ST_LINK,
      ST_PASS,
      ST_DONE
   } state_type;

   localparam logic [NW-1:0] MAXN = NW'(MAX_CLUSTERS);

   state_type     state_ff, state_in;
   logic [MW-1:0] mode_ff, mode_in;
   logic [CW-1:0] first_ff, first_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] cur_ff, cur_in;
   logic [NW-1:0] len_ff, len_in;
   logic [NW-1:0] idx_ff, idx_in;
   logic [NW-1:0] keep_ff, keep_in;
   logic [CW-1:0] last_ff, last_in;
   logic [CW-1:0] amount_ff, amount_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [NW-1:0] scan_ff, scan_in;
   logic [CW-1:0] ss_ff, ss_in;
   logic [NW-1:0] clr_ff, clr_in;
   logic [CW-1:0] cluster_ff, cluster_in;
   logic [SW-1:0] status_ff, status_in;

   logic [NW-1:0] len_nxt;
   logic [NW-1:0] idx_nxt;
   logic [NW-1:0] scan_nxt;
   logic [NW-1:0] pos_inc;
   logic [CW-1:0] pos_wrap;
   logic          pos_skip;

   assign managed  = (csr_count > MAXN) ? MAXN : csr_count;
   assign len_nxt  = len_ff + NW'(1);
   assign idx_nxt  = idx_ff + NW'(1);
   assign scan_nxt = scan_ff + NW'(1);
   assign pos_inc  = {1'b0, pos_ff} + NW'(1);
   assign pos_wrap = (pos_inc == managed) ? '0 : pos_inc[CW-1:0];
   assign pos_skip = (pos_ff == LINK_FREE) || (pos_ff == LINK_END) ||
                     (ram_rd_data != LINK_FREE);

   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      first_in   = first_ff;
      count_in   = count_ff;
      cur_in     = cur_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      keep_in    = keep_ff;
      last_in    = last_ff;
      amount_in  = amount_ff;
      pos_in     = pos_ff;
      scan_in    = scan_ff;
      ss_in      = ss_ff;
      clr_in     = clr_ff;
      cluster_in = cluster_ff;
      status_in  = status_ff;
      ram_wr     = '0;
      ram_rd_addr = cur_ff;
      rem_start  = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = clr_ff[CW-1:0];
            ram_wr.data = LINK_FREE;
            clr_in      = clr_ff + NW'(1);
            if (clr_ff == MAXN - NW'(1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               mode_in    = req.mode;
               first_in   = req.first_cluster;
               count_in   = req.count;
               cluster_in = '0;
               amount_in  = '0;
               status_in  = STAT_OK;
               if (req.mode == MODE_NEW) begin
                  state_in = ST_SRCH_START;
               end else begin
                  ram_rd_addr = req.first_cluster;
                  cur_in      = req.first_cluster;
                  len_in      = '0;
                  state_in    = ST_WALK;
               end
            end
         end

         // read data belongs to cur_ff; follow the link in the same cycle
         ST_WALK: begin
            if (({1'b0, cur_ff} >= managed) || (len_ff >= MAXN) ||
                (ram_rd_data == LINK_FREE)) begin
               status_in = STAT_BROKEN;
               state_in  = ST_DONE;
            end else begin
               len_in = len_nxt;
               if (ram_rd_data == LINK_END) begin
                  last_in     = cur_ff;
                  ram_rd_addr = first_ff;
                  cur_in      = first_ff;
                  idx_in      = '0;
                  unique case (mode_ff)
                     MODE_EXTEND: begin
                        state_in = (count_ff == '0) ? ST_DONE : ST_SRCH_START;
                     end
                     MODE_TRUNC: begin
                        if ({1'b0, count_ff} >= len_nxt) begin
                           status_in = STAT_BROKEN;
                           state_in  = ST_DONE;
                        end else begin
                           keep_in  = len_nxt - {1'b0, count_ff};
                           state_in = ST_PASS;
                        end
                     end
                     MODE_FREE: begin
                        keep_in  = '0;
                        state_in = ST_PASS;
                     end
                     default: begin
                        state_in = ST_DONE;
                     end
                  endcase
               end else begin
                  cur_in      = ram_rd_data;
                  ram_rd_addr = ram_rd_data;
               end
            end
         end

         ST_SRCH_START: begin
            scan_in = '0;
            if (managed == '0) begin
               status_in = STAT_FULL;
               state_in  = ST_DONE;
            end else if ({1'b0, ss_ff} >= managed) begin
               rem_start = 1'b1;
               state_in  = ST_SRCH_MOD;
            end else begin
               pos_in      = ss_ff;
               ram_rd_addr = ss_ff;
               state_in    = ST_SRCH;
            end
         end

         ST_SRCH_MOD: begin
            if (rem_done) begin
               pos_in      = rem_value;
               ram_rd_addr = rem_value;
               state_in    = ST_SRCH;
            end
         end

         // read data belongs to pos_ff; the next position is read ahead
         ST_SRCH: begin
            if (!pos_skip) begin
               ram_wr.en   = 1'b1;
               ram_wr.addr = pos_ff;
               ram_wr.data = LINK_END;
               ss_in       = pos_ff;
               if (mode_ff == MODE_NEW) begin
                  cluster_in = pos_ff;
                  state_in   = ST_DONE;
               end else begin
                  state_in = ST_LINK;
               end
            end else if (scan_nxt == managed) begin
               status_in = STAT_FULL;
               state_in  = ST_DONE;
            end else begin
               scan_in     = scan_nxt;
               pos_in      = pos_wrap;
               ram_rd_addr = pos_wrap;
            end
         end

         ST_LINK: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = last_ff;
            ram_wr.data = pos_ff;
            last_in     = pos_ff;
            amount_in   = amount_ff + CW'(1);
            state_in    = (amount_in == count_ff) ? ST_DONE : ST_SRCH_START;
         end

         // second walk: pass the kept part, mark the new tail, free the rest
         ST_PASS: begin
            if (idx_nxt == keep_ff) begin
               ram_wr.en   = 1'b1;
               ram_wr.addr = cur_ff;
               ram_wr.data = LINK_END;
            end else if (idx_nxt > keep_ff) begin
               ram_wr.en   = 1'b1;
               ram_wr.addr = cur_ff;
               ram_wr.data = LINK_FREE;
            end
            if (ram_rd_data == LINK_END) begin
               state_in = ST_DONE;
            end else begin
               cur_in      = ram_rd_data;
               ram_rd_addr = ram_rd_data;
               idx_in      = idx_nxt;
            end
         end

         ST_DONE: begin
            if (res_taken) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         ss_ff    <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         ss_ff    <= ss_in;
      end
      mode_ff    <= mode_in;
      first_ff   <= first_in;
      count_ff   <= count_in;
      cur_ff     <= cur_in;
      len_ff     <= len_in;
      idx_ff     <= idx_in;
      keep_ff    <= keep_in;
      last_ff    <= last_in;
      amount_ff  <= amount_in;
      pos_ff     <= pos_in;
      scan_ff    <= scan_in;
      cluster_ff <= cluster_in;
      status_ff  <= status_in;
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign res_valid   = (state_ff == ST_DONE);
   assign res.cluster = cluster_ff;
   assign res.amount  = amount_ff;
   assign res.status  = status_ff;
   assign search_ptr  = ss_ff;

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Testbench for the cluster chain allocator: random and directed chain traffic
// checked against a behavioral model of the link table.
`timescale 1ns / 100ps

module testbench;
   import fcca_pkg::*;

   localparam int unsigned STALL_LIMIT   = 200000;  // cycles with no transaction
   localparam int unsigned HOLD_OFF      = 1500;    // long receiver hold-off
   localparam int unsigned RANDOM_ITEMS  = 20;      // per random phase
   localparam int unsigned DRAIN_CYCLES  = 64;

   // Behavioral copy of the allocator: link table, next-fit pointer and the
   // managed cluster count, plus the results still owed by the block.
   class chain_ledger;
      localparam int DEPTH = 4096;

      logic [CW-1:0] links [DEPTH];
      int            path [DEPTH];
      int unsigned   next_fit;
      int unsigned   span_reg;
      rsp_type       owed [$];
      int unsigned   errors;

      function new();
         foreach (links[i]) links[i] = LINK_FREE;
         next_fit = 0;
         span_reg = int'(CSR_RESET);
         errors   = 0;
      endfunction

      function void set_span(logic [NW-1:0] v);
         span_reg = int'(v);
      endfunction

      function int unsigned managed_count();
         return (span_reg > DEPTH) ? DEPTH : span_reg;
      endfunction

      // Next-fit search; skip cluster 0 and the END code, leave the
      // pointer on the cluster taken.
      function int grab();
         int unsigned n;
         int unsigned pos;
         n = managed_count();
         for (int unsigned i = 0; i < n; i++) begin
            pos = (next_fit + i) % n;
            if (pos != 0 && pos != int'(LINK_END) && links[pos] == LINK_FREE) begin
               links[pos] = LINK_END;
               next_fit   = pos;
               return int'(pos);
            end
         end
         return -1;
      endfunction

      // Walk a chain into path; -1 when it leaves the managed range, hits a
      // free entry or runs longer than the table.
      function int follow(logic [CW-1:0] head);
         int unsigned   n;
         int unsigned   cur;
         logic [CW-1:0] v;
         n   = managed_count();
         cur = int'(head);
         for (int len = 0; len < DEPTH; len++) begin
            if (cur >= n) return -1;
            v = links[cur];
            if (v == LINK_FREE) return -1;
            path[len] = int'(cur);
            if (v == LINK_END) return len + 1;
            cur = int'(v);
         end
         return -1;
      endfunction

      // Apply one accepted transaction and queue the result it owes.
      function rsp_type note(req_type tx);
         rsp_type     want;
         int          len;
         int          c;
         int          keep;
         int unsigned tail;
         want = '0;
         if (tx.mode == MODE_NEW) begin
            c = grab();
            if (c < 0) want.status = STAT_FULL;
            else want.cluster = c[CW-1:0];
         end else begin
            len = follow(tx.first_cluster);
            if (len < 0) begin
               want.status = STAT_BROKEN;
            end else if (tx.mode == MODE_EXTEND) begin
               tail = path[len-1];
               while (want.amount < tx.count) begin
                  c = grab();
                  if (c < 0) break;
                  links[tail] = c[CW-1:0];
                  tail        = c;
                  want.amount = want.amount + 1'b1;
               end
               if (want.amount < tx.count) want.status = STAT_FULL;
            end else if (tx.mode == MODE_TRUNC) begin
               if (int'(tx.count) >= len) begin
                  want.status = STAT_BROKEN;
               end else begin
                  keep = len - int'(tx.count);
                  for (int i = keep; i < len; i++) links[path[i]] = LINK_FREE;
                  links[path[keep-1]] = LINK_END;
               end
            end else begin
               for (int i = 0; i < len; i++) links[path[i]] = LINK_FREE;
            end
         end
         owed = {owed, want};
         return want;
      endfunction

      task report(string msg);
         $display("%0t ns  mismatch: %s", $time, msg);
         errors++;
      endtask

      task check(rsp_type got);
         rsp_type want;
         if (owed.size() == 0) begin
            report($sformatf("result with nothing owed: cluster %0d amount %0d status %0d",
                             got.cluster, got.amount, got.status));
            return;
         end
         want = owed.pop_front();
         if (got.cluster !== want.cluster)
            report($sformatf("cluster %0d, want %0d", got.cluster, want.cluster));
         if (got.amount !== want.amount)
            report($sformatf("amount %0d, want %0d", got.amount, want.amount));
         if (got.status !== want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
      endtask
   endclass

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_ready;
   req_type         req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready   = 1'b0;
   rsp_type         rsp_payload;
   logic            csr_wr_en   = 1'b0;
   logic [NW-1:0]   csr_wr_data = '0;

   chain_ledger     book;
   logic [CW-1:0]   heads [$];        // first clusters of files believed alive
   bit              calm          = 1'b0;  // no idling on either side
   bit              hold_off_req  = 1'b0;
   int unsigned     stuck         = 0;

   fat_cluster_chain_allocator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hold reset high from the start, then release it for good.
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // Gap length: mostly none or short, now and then long.
   function automatic int unsigned idle_span();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 120);
   endfunction

   // Watchdog: end the run when no transaction moves on either channel for
   // far longer than the slowest walk, search or hold-off could take.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stuck <= 0;
      else
         stuck <= stuck + 1;
      if (stuck >= STALL_LIMIT) begin
         $display("fat_cluster_chain_allocator verification failed");
         $finish;
      end
   end

   // Receiver: check each accepted result, then pick the next ready value.
   // A hold-off request from the stimulus drops ready for a long stretch so
   // the result register fills and the block stops taking requests.
   initial begin : result_sink
      int unsigned quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) book.check(rsp_payload);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            quiet        = HOLD_OFF;
         end else if (quiet == 0 && $urandom_range(0, 3) == 0) begin
            quiet = idle_span();
         end
         if (quiet > 0) begin
            quiet--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offer one request and hold it until accepted; then update the model,
   // track live files and maybe idle. Valid stays high when no gap follows.
   task automatic issue(input logic [MW-1:0] m, input logic [CW-1:0] f,
                        input logic [CW-1:0] n);
      req_type     tx;
      rsp_type     want;
      int unsigned gap;
      tx.mode          = m;
      tx.first_cluster = f;
      tx.count         = n;
      req_valid   <= 1'b1;
      req_payload <= tx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      want = book.note(tx);
      if (m == MODE_NEW && want.status == STAT_OK) heads = {heads, want.cluster};
      if (m == MODE_FREE && want.status == STAT_OK) begin
         for (int i = 0; i < heads.size(); i++)
            if (heads[i] == f) begin
               heads.delete(i);
               break;
            end
      end
      gap = idle_span();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic release_valid();
      if (req_valid) req_valid <= 1'b0;
   endtask

   // Drain, then write the cluster count while the block is idle.
   task automatic program_span(input logic [NW-1:0] v);
      release_valid();
      while (book.owed.size() != 0) @(posedge clock);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      book.set_span(v);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Random request: mostly operations on live files with small counts,
   // the rest new files and raw noise over the full field ranges.
   task automatic random_request();
      int unsigned   r;
      logic [MW-1:0] m;
      logic [CW-1:0] f;
      logic [CW-1:0] n;
      r = $urandom_range(0, 99);
      f = CW'($urandom_range(0, 4095));
      n = CW'($urandom_range(0, 4095));
      if (r < 18 || heads.size() == 0) begin
         m = MODE_NEW;
      end else if (r < 85) begin
         f = heads[$urandom_range(0, heads.size() - 1)];
         r = $urandom_range(0, 99);
         if (r < 45) begin
            m = MODE_EXTEND;
            n = CW'($urandom_range(0, 6));
         end else if (r < 80) begin
            m = MODE_TRUNC;
            if ($urandom_range(0, 7) != 0) n = CW'($urandom_range(0, 4));
         end else begin
            m = MODE_FREE;
         end
      end else begin
         m = MW'($urandom_range(0, 3));
         // keep noisy extends short so chain walks stay cheap
         if (m == MODE_EXTEND) n = CW'($urandom_range(0, 63));
      end
      issue(m, f, n);
   endtask

   initial begin : stimulus
      logic [NW-1:0] spans [6];
      book     = new();
      spans[0] = 13'd8191;
      spans[1] = 13'd4096;
      spans[2] = 13'd40;
      spans[3] = 13'd300;
      spans[4] = 13'd16;
      spans[5] = 13'd4096;

      do @(posedge clock); while (reset);

      // Full table, written during the clearing pass.
      program_span(CSR_RESET);
      issue(MODE_TRUNC, 12'd0, 12'd0);           // chain starts on a free entry
      issue(MODE_NEW, 12'hFFF, 12'hFFF);         // ignored fields all ones; takes 1
      issue(MODE_NEW, 12'd0, 12'd0);
      issue(MODE_EXTEND, 12'd1, 12'd3);
      issue(MODE_TRUNC, 12'd1, 12'd0);           // only rewrites the tail
      issue(MODE_TRUNC, 12'd1, 12'd4);           // count equals chain length
      issue(MODE_TRUNC, 12'd1, 12'hFFF);
      issue(MODE_TRUNC, 12'd1, 12'd2);
      issue(MODE_EXTEND, 12'd2, 12'd0);
      issue(MODE_EXTEND, 12'hFFF, 12'd1);        // reserved cluster, always free
      issue(MODE_FREE, 12'd2, 12'd0);
      issue(MODE_FREE, 12'd2, 12'd0);            // second free finds a free entry
      issue(MODE_FREE, 12'hFFF, 12'hFFF);
      issue(MODE_EXTEND, 12'd1, 12'd255);        // push the search pointer far out
      issue(MODE_FREE, 12'd1, 12'd0);

      // Tiny table: the pointer lies past the count, extend runs short,
      // then the table is full.
      program_span(13'd4);
      issue(MODE_NEW, 12'd0, 12'd0);
      issue(MODE_EXTEND, heads[$], 12'hFFF);
      issue(MODE_NEW, 12'd0, 12'd0);
      issue(MODE_TRUNC, heads[$], 12'd1);
      issue(MODE_FREE, heads[$], 12'd0);

      // No managed clusters at all.
      program_span(13'd0);
      issue(MODE_NEW, 12'd0, 12'd0);
      issue(MODE_EXTEND, 12'd0, 12'd1);

      // Only cluster 0, which is never handed out.
      program_span(13'd1);
      issue(MODE_NEW, 12'd0, 12'd0);

      // One usable cluster: extend gets nothing.
      program_span(13'd2);
      issue(MODE_NEW, 12'd0, 12'd0);
      issue(MODE_EXTEND, 12'd1, 12'd5);
      issue(MODE_FREE, 12'd1, 12'd0);

      // Random phases over several table sizes. Files made under a large
      // size turn into broken chains under a small one.
      foreach (spans[p]) begin
         program_span(spans[p]);
         if (p == 1) begin
            // back-to-back requests against a stalled receiver
            calm         = 1'b1;
            hold_off_req = 1'b1;
         end
         if (p == 3) calm = 1'b1;
         for (int i = 0; i < RANDOM_ITEMS; i++) random_request();
         calm = 1'b0;
      end

      release_valid();
      while (book.owed.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (book.errors == 0 && book.owed.size() == 0)
         $display("fat_cluster_chain_allocator verification clean");
      else
         $display("fat_cluster_chain_allocator verification failed");
      $finish;
   end

endmodule
